// ----- rtl/core/gds_pkg.sv -----
// Shared types, codes and calendar helpers for the Gregorian date stepper.
`timescale 1ns / 1ps

package gds_pkg;

    localparam int YEAR_WIDTH  = 16;
    localparam int COUNT_WIDTH = 16;

    localparam logic [YEAR_WIDTH-1:0] YEAR_RESET = YEAR_WIDTH'(2000);

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_COMPARE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_LOAD = 2'd1,
        STAT_WRAP     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEAP,
        ST_STEP
    } state_t;

    // Inverse of an odd number modulo 2^64, by Newton iteration.
    function automatic logic [63:0] odd_inverse(input logic [63:0] d);
        logic [63:0] x;
        x = d;
        for (int i = 0; i < 6; i++) begin
            x = x * (64'd2 - d * x);
        end
        return x;
    endfunction

    // y divisible by 25 <=> y * inv(25) mod 2^W <= (2^W - 1) / 25
    localparam logic [YEAR_WIDTH-1:0] INV25 = YEAR_WIDTH'(odd_inverse(64'd25));
    localparam logic [YEAR_WIDTH-1:0] DIV25_LIMIT =
        YEAR_WIDTH'(((64'd1 << YEAR_WIDTH) - 64'd1) / 64'd25);

    // Month length; codes outside 1..12 read as 31.
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/core/gregorian_date_stepper_unit.sv -----
// Top level of the Gregorian date stepper: date registers, day-step sequencer, result register.
`timescale 1ns / 1ps

// Usage:
//   The block holds one Gregorian date (year, month, day), 2000-01-01 after reset.
//   Input transactions arrive on the s_ stream; s_tuser carries the operation
//   (load, advance, compare) and s_tdata the operands. Every input transaction
//   yields exactly one result transaction on the m_ stream with the stored
//   date after the operation, the compare flags and a status code.
//   Sequence per operation:
//     load, compare, unused code : result registered in the cycle after acceptance.
//     advance by N days          : a leap refresh (ST_LEAP) after acceptance, then
//                                  one day stepped per cycle in ST_STEP by the shared
//                                  day-step unit, with a further leap refresh at each
//                                  year change; the result is registered when the
//                                  last day is stepped or after the last refresh.
//   The block takes one item at a time: s_tready is high only while the
//   sequencer is idle and the result register is empty or being drained.
//   When the receiver stalls, the result holds in the output register and
//   no new item is accepted until it is taken.
//   Reset (aresetn low, synchronous) restores 2000-01-01 and empties the
//   result register.
module gregorian_date_stepper_unit
    import gds_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] year_in, [19:16] month_in, [24:20] day_in, [40:25] shift_count, [47:41] zero
    input  logic [47:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] year_out, [19:16] month_out, [24:20] day_out, [25] is_less,
    // [26] is_equal, [28:27] status, [31:29] zero
    output logic [31:0] m_tdata
);

    // Unpack the input transaction.
    logic [1:0]             op_in;
    logic [YEAR_WIDTH-1:0]  year_in;
    logic [3:0]             month_in;
    logic [4:0]             day_in;
    logic [COUNT_WIDTH-1:0] count_in;

    assign op_in    = s_tuser;
    assign year_in  = YEAR_WIDTH'(s_tdata[15:0]);
    assign month_in = s_tdata[19:16];
    assign day_in   = s_tdata[24:20];
    assign count_in = COUNT_WIDTH'(s_tdata[40:25]);

    state_t                 state_reg, state_next;
    logic [YEAR_WIDTH-1:0]  year_reg, year_next;
    logic [3:0]             month_reg, month_next;
    logic [4:0]             day_reg, day_next;
    logic                   leap_reg, leap_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    status_t                stat_reg, stat_next;

    logic                   out_valid_reg, out_valid_next;
    logic [YEAR_WIDTH-1:0]  out_year_reg, out_year_next;
    logic [3:0]             out_month_reg, out_month_next;
    logic [4:0]             out_day_reg, out_day_next;
    logic                   out_less_reg, out_less_next;
    logic                   out_equal_reg, out_equal_next;
    status_t                out_stat_reg, out_stat_next;

    logic accept;
    logic slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;

    // Leap test of the stored year: by 4, and by 400 where by 100.
    logic [YEAR_WIDTH-1:0] inv_prod;
    logic                  div25;
    logic                  leap_calc;

    assign inv_prod  = YEAR_WIDTH'(year_reg * INV25);
    assign div25     = (inv_prod <= DIV25_LIMIT);
    assign leap_calc = (year_reg[1:0] == 2'd0) && (!div25 || (year_reg[3:0] == 4'd0));

    // Shared day-step unit: one calendar day forward from the stored date.
    logic [4:0]            len_cur;
    logic                  day_roll;
    logic                  year_roll;
    logic [YEAR_WIDTH-1:0] year_inc;

    assign len_cur   = month_len(month_reg, leap_reg);
    assign day_roll  = !(day_reg < len_cur);
    assign year_roll = day_roll && (month_reg >= 4'd12);
    assign year_inc  = year_reg + YEAR_WIDTH'(1);

    // Compare stored date against the operands.
    logic cmp_less;
    logic cmp_equal;

    always_comb begin
        cmp_less  = 1'b0;
        cmp_equal = 1'b0;
        if (year_reg != year_in) begin
            cmp_less = year_reg < year_in;
        end else if (month_reg != month_in) begin
            cmp_less = month_reg < month_in;
        end else if (day_reg != day_in) begin
            cmp_less = day_reg < day_in;
        end else begin
            cmp_equal = 1'b1;
        end
    end

    logic load_ok;
    assign load_ok = (month_in >= 4'd1) && (month_in <= 4'd12) && (day_in != 5'd0);

    logic count_last;
    assign count_last = (count_reg == COUNT_WIDTH'(1));

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (op_in == OP_ADVANCE)) begin
                    state_next = ST_LEAP;
                end
            end
            ST_LEAP: begin
                // refresh the leap flag, then step or finish
                if (count_reg != '0) begin
                    state_next = ST_STEP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEP: begin
                if (year_roll) begin
                    state_next = ST_LEAP;
                end else if (count_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and result register updates.
    always_comb begin
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        leap_next      = leap_reg;
        count_next     = count_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_year_next  = out_year_reg;
        out_month_next = out_month_reg;
        out_day_next   = out_day_reg;
        out_less_next  = out_less_reg;
        out_equal_next = out_equal_reg;
        out_stat_next  = out_stat_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    out_less_next  = 1'b0;
                    out_equal_next = 1'b0;
                    out_stat_next  = STAT_OK;
                    out_year_next  = year_reg;
                    out_month_next = month_reg;
                    out_day_next   = day_reg;
                    case (op_in)
                        OP_LOAD: begin
                            out_valid_next = 1'b1;
                            if (load_ok) begin
                                year_next      = year_in;
                                month_next     = month_in;
                                day_next       = day_in;
                                out_year_next  = year_in;
                                out_month_next = month_in;
                                out_day_next   = day_in;
                            end else begin
                                out_stat_next = STAT_BAD_LOAD;
                            end
                        end
                        OP_ADVANCE: begin
                            count_next = count_in;
                            stat_next  = STAT_OK;
                        end
                        OP_COMPARE: begin
                            out_valid_next = 1'b1;
                            out_less_next  = cmp_less;
                            out_equal_next = cmp_equal;
                        end
                        default: begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_LEAP: begin
                leap_next = leap_calc;
                if (count_reg == '0) begin
                    out_valid_next = 1'b1;
                    out_year_next  = year_reg;
                    out_month_next = month_reg;
                    out_day_next   = day_reg;
                    out_less_next  = 1'b0;
                    out_equal_next = 1'b0;
                    out_stat_next  = stat_reg;
                end
            end
            ST_STEP: begin
                count_next = count_reg - COUNT_WIDTH'(1);
                if (!day_roll) begin
                    day_next = day_reg + 5'd1;
                end else begin
                    day_next = 5'd1;
                    if (year_roll) begin
                        month_next = 4'd1;
                        year_next  = year_inc;
                        if (year_inc == '0) begin
                            stat_next = STAT_WRAP;
                        end
                    end else begin
                        month_next = month_reg + 4'd1;
                    end
                end
                // finish here unless a year change needs a leap refresh first
                if (!year_roll && count_last) begin
                    out_valid_next = 1'b1;
                    out_year_next  = year_next;
                    out_month_next = month_next;
                    out_day_next   = day_next;
                    out_less_next  = 1'b0;
                    out_equal_next = 1'b0;
                    out_stat_next  = stat_next;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            year_reg      <= YEAR_RESET;
            month_reg     <= 4'd1;
            day_reg       <= 5'd1;
            leap_reg      <= 1'b1;
            count_reg     <= '0;
            stat_reg      <= STAT_OK;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            leap_reg      <= leap_next;
            count_reg     <= count_next;
            stat_reg      <= stat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_year_reg  <= out_year_next;
        out_month_reg <= out_month_next;
        out_day_reg   <= out_day_next;
        out_less_reg  <= out_less_next;
        out_equal_reg <= out_equal_next;
        out_stat_reg  <= out_stat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_stat_reg, out_equal_reg, out_less_reg,
                       out_day_reg, out_month_reg, 16'(out_year_reg)};

endmodule

// ----- tb/sv/gregorian_date_stepper_checker.sv -----
// Result checker for the date stepper: tracks the calendar date and compares every result.
`timescale 1ns / 1ps

module gregorian_date_stepper_checker
    import gds_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          errors,
    output int          pending
);

    localparam int MAX_REPORTS = 60;

    // Same layout as m_tdata[28:0]: year in the low bits.
    typedef struct packed {
        status_t                 status;
        logic                    equal;
        logic                    less;
        logic [4:0]              day;
        logic [3:0]              month;
        logic [YEAR_WIDTH-1:0]   year;
    } date_result_t;

    logic [YEAR_WIDTH-1:0] cal_year;
    logic [3:0]            cal_month;
    logic [4:0]            cal_day;
    date_result_t          expected_dates[$];
    int                    fail_count = 0;
    int                    queued     = 0;
    int                    reports    = 0;

    assign errors  = fail_count;
    assign pending = queued;

    function automatic bit is_leap(input logic [YEAR_WIDTH-1:0] y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic logic [4:0] days_in_month(input logic [3:0] m,
                                                 input logic [YEAR_WIDTH-1:0] y);
        logic [4:0] n;
        case (m)
            4'd2:                    n = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:                 n = 5'd31;
        endcase
        return n;
    endfunction

    // Apply one operation to the tracked date and return the result it must produce.
    function automatic date_result_t apply_operation(input op_t op,
                                                     input logic [YEAR_WIDTH-1:0] y,
                                                     input logic [3:0] m,
                                                     input logic [4:0] d,
                                                     input logic [COUNT_WIDTH-1:0] count);
        date_result_t r;
        logic [COUNT_WIDTH-1:0] left;
        r = '0;
        r.status = STAT_OK;
        left = count;
        case (op)
            OP_LOAD: begin
                if (m >= 4'd1 && m <= 4'd12 && d != 5'd0) begin
                    cal_year  = y;
                    cal_month = m;
                    cal_day   = d;
                end else begin
                    r.status = STAT_BAD_LOAD;
                end
            end
            OP_ADVANCE: begin
                while (left != 0) begin
                    // A day loaded past the month end rolls straight to the 1st.
                    if (cal_day < days_in_month(cal_month, cal_year)) begin
                        cal_day = cal_day + 5'd1;
                    end else begin
                        cal_day = 5'd1;
                        if (cal_month >= 4'd12) begin
                            cal_month = 4'd1;
                            cal_year  = cal_year + 1'b1;
                            if (cal_year == 0) r.status = STAT_WRAP;
                        end else begin
                            cal_month = cal_month + 4'd1;
                        end
                    end
                    left = left - 1'b1;
                end
            end
            OP_COMPARE: begin
                if (cal_year != y)        r.less = cal_year < y;
                else if (cal_month != m)  r.less = cal_month < m;
                else if (cal_day != d)    r.less = cal_day < d;
                else                      r.equal = 1'b1;
            end
            default: ;
        endcase
        r.year  = cal_year;
        r.month = cal_month;
        r.day   = cal_day;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            if (reports < MAX_REPORTS) begin
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
            reports++;
        end
    endtask

    always @(posedge aclk) begin
        date_result_t got;
        date_result_t want;
        if (!aresetn) begin
            cal_year  = YEAR_RESET;
            cal_month = 4'd1;
            cal_day   = 5'd1;
            expected_dates.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = date_result_t'(m_tdata[28:0]);
                if (expected_dates.size() == 0) begin
                    fail_count++;
                    if (reports < MAX_REPORTS) begin
                        $display("%0t ns: result with none expected, got %0d-%0d-%0d status %0d",
                                 $time, got.year, got.month, got.day, got.status);
                    end
                    reports++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("year", want.year, got.year);
                    check_field("month", want.month, got.month);
                    check_field("day", want.day, got.day);
                    check_field("is_less", want.less, got.less);
                    check_field("is_equal", want.equal, got.equal);
                    check_field("status", want.status, got.status);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_dates.push_back(apply_operation(op_t'(s_tuser), s_tdata[15:0],
                                                         s_tdata[19:16], s_tdata[24:20],
                                                         s_tdata[40:25]));
            end
        end
        queued = expected_dates.size();
    end

endmodule

// ----- tb/sv/gregorian_date_stepper_unit_test.sv -----
// Top of the date stepper testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module gregorian_date_stepper_unit_test;
    import gds_pkg::*;

    localparam int  RANDOM_PER_PHASE = 206;     // four phases plus the directed list, ~850 items
    localparam int  HOLD_CYCLES      = 300;     // long receiver hold-off, fills the block
    localparam int  DRAIN_CYCLES     = 20;      // idle tail after the last result
    localparam longint LIMIT_CYCLES  = 3000000; // far beyond the slowest legal run

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [15:0] year_in, [19:16] month_in, [24:20] day_in, [40:25] shift_count, [47:41] zero
    logic [47:0] s_tdata  = '0;
    // [1:0] operation
    logic [1:0]  s_tuser  = OP_LOAD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [15:0] year_out, [19:16] month_out, [24:20] day_out, [25] is_less,
    // [26] is_equal, [28:27] status, [31:29] zero
    logic [31:0] m_tdata;

    int     error_count;
    int     results_pending;

    // Flow-control knobs, in percent of cycles.
    int     idle_pct  = 0;
    int     stall_pct = 0;

    // Long hold-off handshake between the stimulus and the receiver process.
    int     hold_requests = 0;
    int     holds_served  = 0;
    int     hold_left     = 0;

    longint cycle_count = 0;

    // Coverage tallies for the closing summary.
    int     n_load = 0, n_rejected = 0, n_advance = 0, n_compare = 0, n_unused = 0;
    longint days_stepped = 0;

    gregorian_date_stepper_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    gregorian_date_stepper_checker result_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (error_count),
        .pending  (results_pending)
    );

    // 4 ns clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Guard against a hung block: end the run once the cycle budget is spent.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, results_pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off for a long stretch when asked.
    // Count the hold-off here so it runs independently of the sender.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            m_tready     <= 1'b0;
            hold_left    <= HOLD_CYCLES - 1;
            holds_served <= holds_served + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one transaction and hold it until the block accepts it.
    // Drive at the falling edge, sample the handshake at the rising edge.
    task automatic send_item(input op_t op, input logic [15:0] y, input logic [3:0] m,
                             input logic [4:0] d, input logic [15:0] n);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, n, d, m, y};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        case (op)
            OP_LOAD: begin
                n_load++;
                if (m < 4'd1 || m > 4'd12 || d == 5'd0) n_rejected++;
            end
            OP_ADVANCE: begin
                n_advance++;
                days_stepped += n;
            end
            OP_COMPARE: n_compare++;
            default:    n_unused++;
        endcase
    endtask

    // Bias years toward the top of the range (wrap) and whole centuries (leap rule).
    function automatic logic [15:0] pick_year();
        case ($urandom_range(9))
            0, 1:    return 16'hFFFF - 16'($urandom_range(3));
            2, 3:    return 16'($urandom_range(655) * 100);
            default: return 16'($urandom);
        endcase
    endfunction

    // Favor days near the month end so rollovers and over-long days show up.
    function automatic logic [4:0] pick_day();
        if ($urandom_range(1)) return 5'($urandom_range(31, 26));
        return 5'($urandom_range(31, 1));
    endfunction

    // Keep most advances short; a few run the full count range.
    function automatic logic [15:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 16'($urandom_range(40));
        if (r < 88) return 16'($urandom_range(400));
        if (r < 98) return 16'($urandom_range(3000));
        return 16'($urandom);
    endfunction

    // Nudge one operand to land just beside the reference value, on it, or anywhere.
    function automatic logic [15:0] near16(input logic [15:0] v);
        case ($urandom_range(3))
            0:       return v + 16'd1;
            1:       return v - 16'd1;
            2:       return 16'($urandom);
            default: return v;
        endcase
    endfunction

    // Random part of one phase: mostly load / compare / advance sequences on a
    // known date, the rest unconstrained noise including bad loads and code 3.
    task automatic run_random(input int target, input bit with_hold);
        int          sent;
        bit          hold_fired;
        logic [15:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        sent = 0;
        hold_fired = 1'b0;
        while (sent < target) begin
            if (with_hold && !hold_fired && sent >= target / 2) begin
                hold_requests <= hold_requests + 1;
                hold_fired = 1'b1;
            end
            if ($urandom_range(99) < 80) begin
                y = pick_year();
                m = 4'($urandom_range(12, 1));
                d = pick_day();
                send_item(OP_LOAD, y, m, d, 16'($urandom));
                send_item(OP_COMPARE, y, m, d, 16'($urandom));
                sent += 2;
                repeat ($urandom_range(3, 1)) begin
                    if ($urandom_range(1)) begin
                        send_item(OP_ADVANCE, 16'($urandom), 4'($urandom), 5'($urandom),
                                  pick_count());
                    end else begin
                        send_item(OP_COMPARE, near16(y),
                                  $urandom_range(1) ? 4'(near16(16'(m))) : m,
                                  $urandom_range(1) ? 5'(near16(16'(d))) : d,
                                  16'($urandom));
                    end
                    sent++;
                end
            end else begin
                send_item(op_t'($urandom_range(3)), 16'($urandom), 4'($urandom),
                          5'($urandom), pick_count());
                sent++;
            end
        end
    endtask

    initial begin
        // Hold reset at the start, once.
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: leap rules, bad loads, day past month end, year wrap,
        // every compare outcome, the unused code and both count extremes.
        send_item(OP_COMPARE, 16'd2000, 4'd1, 5'd1, 16'd0);
        send_item(OP_ADVANCE, 16'd0, 4'd0, 5'd0, 16'd0);
        send_item(OP_ADVANCE, 16'd0, 4'd0, 5'd0, 16'd59);
        send_item(OP_ADVANCE, 16'd0, 4'd0, 5'd0, 16'd1);
        send_item(OP_LOAD, 16'd1900, 4'd2, 5'd28, 16'd0);
        send_item(OP_ADVANCE, 16'd0, 4'd0, 5'd0, 16'd1);
        send_item(OP_LOAD, 16'd2024, 4'd2, 5'd28, 16'd0);
        send_item(OP_ADVANCE, 16'd0, 4'd0, 5'd0, 16'd1);
        send_item(OP_LOAD, 16'd1999, 4'd0, 5'd10, 16'd0);
        send_item(OP_LOAD, 16'd1999, 4'd13, 5'd10, 16'd0);
        send_item(OP_LOAD, 16'hFFFF, 4'd15, 5'd31, 16'hFFFF);
        send_item(OP_LOAD, 16'd1999, 4'd5, 5'd0, 16'd0);
        send_item(OP_LOAD, 16'd2023, 4'd4, 5'd31, 16'd0);
        send_item(OP_ADVANCE, 16'd0, 4'd0, 5'd0, 16'd1);
        send_item(OP_LOAD, 16'hFFFF, 4'd12, 5'd31, 16'd0);
        send_item(OP_ADVANCE, 16'd0, 4'd0, 5'd0, 16'd1);
        send_item(OP_ADVANCE, 16'd0, 4'd0, 5'd0, 16'd59);
        send_item(OP_COMPARE, 16'd0, 4'd2, 5'd29, 16'd0);
        send_item(OP_COMPARE, 16'hFFFF, 4'd15, 5'd31, 16'd0);
        send_item(OP_COMPARE, 16'd0, 4'd2, 5'd28, 16'd0);
        send_item(OP_COMPARE, 16'd0, 4'd1, 5'd31, 16'd0);
        send_item(OP_COMPARE, 16'd0, 4'd3, 5'd0, 16'd0);
        send_item(OP_NONE, 16'hFFFF, 4'd15, 5'd31, 16'hFFFF);
        send_item(OP_LOAD, 16'd0, 4'd1, 5'd1, 16'd0);
        send_item(OP_ADVANCE, 16'd0, 4'd0, 5'd0, 16'hFFFF);

        // Random phases; pause the sender until all results are back between them.
        run_random(RANDOM_PER_PHASE, 1'b1);
        s_tvalid <= 1'b0;
        wait (results_pending == 0);
        @(negedge aclk);

        idle_pct  = 47;
        stall_pct = 0;
        run_random(RANDOM_PER_PHASE, 1'b0);
        s_tvalid <= 1'b0;
        wait (results_pending == 0);
        @(negedge aclk);

        idle_pct  = 0;
        stall_pct = 47;
        run_random(RANDOM_PER_PHASE, 1'b0);
        s_tvalid <= 1'b0;
        wait (results_pending == 0);
        @(negedge aclk);

        idle_pct  = 9;
        stall_pct = 9;
        run_random(RANDOM_PER_PHASE, 1'b0);
        s_tvalid <= 1'b0;

        // Drain: wait for the last result, then watch for strays.
        wait (results_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $write("Sent %0d loads (%0d rejected), %0d advances over %0d days, ",
               n_load, n_rejected, n_advance, days_stepped);
        $display("%0d compares, %0d unused codes", n_compare, n_unused);
        $write("Flow control: sender/receiver idle 0/0, 47/0, 0/47, 9/9 percent, ");
        $display("one %0d-cycle hold-off", HOLD_CYCLES);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/gds_pkg.sv
rtl/core/gregorian_date_stepper_unit.sv
tb/sv/gregorian_date_stepper_checker.sv
tb/sv/gregorian_date_stepper_unit_test.sv
